// ===== hw/rtl/bbs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the buoyancy source unit.
// No dependencies; used by every RTL file and the checker.
package bbs_pkg;

    localparam int DATA_W              = 32;
    localparam int SIZE_W              = 31;
    localparam int CNT_W               = 10;
    localparam int TAB_IDX_W           = 9;
    localparam int CFG_IDX_W           = 3;
    localparam int PROFILE_DEPTH_DEF   = 512;
    localparam int CELL_INDEX_BITS_DEF = 12;

    localparam logic [DATA_W-1:0] GRAVITY_X_RST   = 32'h0000_0000;
    localparam logic [DATA_W-1:0] GRAVITY_Y_RST   = 32'h0000_0000;
    localparam logic [DATA_W-1:0] GRAVITY_Z_RST   = 32'hFFF6_30A4;
    localparam logic [DATA_W-1:0] AXIS_ORIGIN_RST = 32'h0000_0000;
    localparam logic [SIZE_W-1:0] CELL_SIZE_RST   = 31'h0001_0000;
    localparam logic [CNT_W-1:0]  PROFILE_CNT_RST = 10'd1;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CELL  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRAVITY_X     = 3'd0,
        CFG_GRAVITY_Y     = 3'd1,
        CFG_GRAVITY_Z     = 3'd2,
        CFG_AXIS_ORIGIN   = 3'd3,
        CFG_CELL_SIZE     = 3'd4,
        CFG_PROFILE_COUNT = 3'd5
    } t_cfg_idx;

    // One profile entry as stored: height in the upper half.
    typedef struct packed {
        logic signed [DATA_W-1:0] height;
        logic signed [DATA_W-1:0] temperature;
    } t_entry;

endpackage

// ===== hw/rtl/bbs_profile_mem.sv =====
`timescale 1ns / 1ps
// Profile table: one write port, one read port, registered read data.
// Depends on bbs_pkg for the entry type.
module bbs_profile_mem #(
    parameter int DEPTH = bbs_pkg::PROFILE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic           i_clk,
    input  logic           i_we,
    input  logic [AW-1:0]  i_waddr,
    input  bbs_pkg::t_entry i_wdata,
    input  logic [AW-1:0]  i_raddr,
    output bbs_pkg::t_entry o_rdata
);

    bbs_pkg::t_entry r_mem [DEPTH];
    bbs_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/boussinesq_buoyancy_source_unit.sv =====
`timescale 1ns / 1ps
// Buoyancy source unit: sequencer, arithmetic and configuration registers.
// Depends on bbs_pkg and bbs_profile_mem.
//
// A write item (opcode 0) stores one height/temperature pair of the mean
// profile in a single-port-read memory and gives no result. A cell item
// (opcode 1) forms the cell-centre height, walks the profile one entry per
// cycle from the bottom to find its segment (the memory read port sets this
// pace), divides for the interpolation weight one quotient bit per cycle
// for 32 quotient bits, then applies beta with its own multiplier and
// gravity with one multiplier shared by the three components, one component
// at a time. The unit stays busy while the finished result waits for the
// output register to free up. One item is worked on at a time; a finished
// result waits in the output register while the next item is accepted.
// All values are signed Q16.16, beta is unsigned Q0.32, every product
// truncates toward zero and each output saturates to 32 bits.
// Configuration writes are taken in any cycle and must come only while the
// unit is idle.
module boussinesq_buoyancy_source_unit #(
    parameter int PROFILE_DEPTH   = bbs_pkg::PROFILE_DEPTH_DEF,
    parameter int CELL_INDEX_BITS = bbs_pkg::CELL_INDEX_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration write channel
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [bbs_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [bbs_pkg::DATA_W-1:0]             i_cfg_data,
    // input item channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic                                   i_opcode,
    input  logic [bbs_pkg::TAB_IDX_W-1:0]          i_table_index,
    input  logic signed [bbs_pkg::DATA_W-1:0]      i_table_height,
    input  logic signed [bbs_pkg::DATA_W-1:0]      i_table_temperature,
    input  logic [CELL_INDEX_BITS-1:0]             i_cell_index,
    input  logic [bbs_pkg::DATA_W-1:0]             i_expansion_coeff,
    input  logic signed [bbs_pkg::DATA_W-1:0]      i_ref_temperature,
    input  logic signed [bbs_pkg::DATA_W-1:0]      i_src_in_x,
    input  logic signed [bbs_pkg::DATA_W-1:0]      i_src_in_y,
    input  logic signed [bbs_pkg::DATA_W-1:0]      i_src_in_z,
    // result channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [bbs_pkg::DATA_W-1:0]      o_src_out_x,
    output logic signed [bbs_pkg::DATA_W-1:0]      o_src_out_y,
    output logic signed [bbs_pkg::DATA_W-1:0]      o_src_out_z
);

    localparam int DW   = bbs_pkg::DATA_W;
    localparam int AW   = $clog2(PROFILE_DEPTH);
    localparam int CW   = $clog2(PROFILE_DEPTH + 1);
    localparam int X2W  = CELL_INDEX_BITS + 34;   // doubled height, exact
    localparam int DENW = DW + 1;                 // segment span, doubled
    localparam int PW   = DW + 1;                 // 33-bit magnitudes
    localparam int GW   = 2 * DW + 1 - 16;        // gravity * fac >> 16
    localparam int SW   = GW + 1;                 // signed sum width

    typedef enum logic [3:0] {
        S_IDLE, S_X2, S_H0, S_HN, S_SCAN, S_PREP, S_DIV,
        S_MUL, S_TEMP, S_FAC, S_GMUL, S_GADD, S_DONE
    } t_state;

    typedef enum logic [1:0] {COMP_X, COMP_Y, COMP_Z} t_comp;

    // configuration
    logic signed [DW-1:0]            r_grav_x, r_grav_y, r_grav_z, r_origin;
    logic [bbs_pkg::SIZE_W-1:0]      r_cell_size;
    logic [bbs_pkg::CNT_W-1:0]       r_prof_cnt;

    // control
    t_state                          r_state;
    t_comp                           r_comp;
    logic [4:0]                      r_bit;
    logic [AW-1:0]                   r_k;
    logic [CW-1:0]                   r_n;
    logic                            r_out_valid;

    // item and datapath
    logic [CELL_INDEX_BITS-1:0]      r_cidx;
    logic [DW-1:0]                   r_beta;
    logic signed [DW-1:0]            r_tref;
    logic signed [DW-1:0]            r_src [3];
    logic signed [DW-1:0]            r_res [3];
    logic signed [X2W-1:0]           r_x2;
    bbs_pkg::t_entry                 r_lo, r_hi, r_last;
    logic [DENW-1:0]                 r_rem, r_den;
    logic [DW-1:0]                   r_frac;
    logic [PW-1:0]                   r_pmag;
    logic                            r_pneg;
    logic signed [DW-1:0]            r_temp;
    logic [PW-1:0]                   r_fmag;
    logic                            r_fneg;
    logic [GW-1:0]                   r_gmag;
    logic                            r_gneg;
    logic signed [DW-1:0]            r_out_x, r_out_y, r_out_z;

    // memory port
    logic                            mem_we;
    logic [AW-1:0]                   mem_raddr;
    bbs_pkg::t_entry                 mem_wdata, mem_q;

    // combinational datapath
    logic                            in_acc;
    logic [CW-1:0]                   n_n;
    logic signed [X2W-1:0]           n_x2, q_h2, lo_h2, hi_h2;
    logic [CELL_INDEX_BITS+bbs_pkg::SIZE_W:0] x2_prod;
    logic [DENW:0]                   rem2;
    logic signed [PW-1:0]            dt, diff;
    logic [PW-1:0]                   dt_mag, diff_mag;
    logic [PW+DW-1:0]                pprod, fprod;
    logic signed [PW:0]              pval;
    logic signed [DW-1:0]            grav;
    logic [DW-1:0]                   gmag;
    logic [PW+DW-1:0]                gprod;
    logic signed [SW-1:0]            gval, gsum;
    logic signed [DW-1:0]            gsat;
    logic [CW-1:0]                   k_next;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;

    // Write items go straight into the table; out-of-range indexes drop.
    assign mem_we = in_acc && (i_opcode == bbs_pkg::OP_WRITE)
                    && (32'(i_table_index) < 32'(PROFILE_DEPTH));
    assign mem_wdata = '{height: i_table_height, temperature: i_table_temperature};

    bbs_profile_mem #(
        .DEPTH (PROFILE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (AW'(i_table_index)),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_q)
    );

    // Effective entry count: zero acts as one, clamp to the table depth.
    always_comb begin
        if (r_prof_cnt == '0) begin
            n_n = CW'(1);
        end else if (32'(r_prof_cnt) > 32'(PROFILE_DEPTH)) begin
            n_n = CW'(PROFILE_DEPTH);
        end else begin
            n_n = CW'(r_prof_cnt);
        end
    end

    assign k_next = CW'(r_k) + CW'(1);

    // Read address: entry 0, then the last entry, then the scan upward.
    always_comb begin
        unique case (r_state)
            S_X2:    mem_raddr = '0;
            S_H0:    mem_raddr = AW'(r_n - CW'(1));
            S_HN:    mem_raddr = AW'(1);
            S_SCAN:  mem_raddr = AW'(k_next);
            default: mem_raddr = r_k;
        endcase
    end

    // Cell-centre height doubled: 2*origin + (2*index + 1) * size.
    assign x2_prod = {r_cidx, 1'b1} * r_cell_size;
    assign n_x2    = X2W'(signed'({r_origin, 1'b0})) + X2W'(signed'({1'b0, x2_prod}));
    assign q_h2    = X2W'(signed'({mem_q.height, 1'b0}));
    assign lo_h2   = X2W'(signed'({r_lo.height, 1'b0}));
    assign hi_h2   = X2W'(signed'({r_hi.height, 1'b0}));

    // Restoring division step.
    assign rem2 = {r_rem, 1'b0};

    // Interpolation increment, truncated toward zero.
    assign dt     = PW'(r_hi.temperature) - PW'(r_lo.temperature);
    assign dt_mag = dt[PW-1] ? PW'(-dt) : PW'(dt);
    assign pprod  = dt_mag * r_frac;
    assign pval   = r_pneg ? -signed'({1'b0, r_pmag}) : signed'({1'b0, r_pmag});

    // fac = (temp - ref) * beta, truncated toward zero.
    assign diff     = PW'(r_temp) - PW'(r_tref);
    assign diff_mag = diff[PW-1] ? PW'(-diff) : PW'(diff);
    assign fprod    = diff_mag * r_beta;

    // Gravity product for the current component, then saturating add.
    always_comb begin
        unique case (r_comp)
            COMP_X:  grav = r_grav_x;
            COMP_Y:  grav = r_grav_y;
            default: grav = r_grav_z;
        endcase
    end
    assign gmag  = grav[DW-1] ? DW'(-grav) : DW'(grav);
    assign gprod = r_fmag * gmag;
    assign gval  = r_gneg ? -signed'({1'b0, r_gmag}) : signed'({1'b0, r_gmag});
    assign gsum  = SW'(r_src[r_comp]) + gval;

    always_comb begin
        if (gsum > SW'(signed'({1'b0, {(DW-1){1'b1}}}))) begin
            gsat = {1'b0, {(DW-1){1'b1}}};
        end else if (gsum < -SW'(signed'({1'b0, 1'b1, {(DW-1){1'b0}}}))) begin
            gsat = {1'b1, {(DW-1){1'b0}}};
        end else begin
            gsat = DW'(gsum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_comp      <= COMP_X;
            r_bit       <= '0;
            r_k         <= '0;
            r_grav_x    <= bbs_pkg::GRAVITY_X_RST;
            r_grav_y    <= bbs_pkg::GRAVITY_Y_RST;
            r_grav_z    <= bbs_pkg::GRAVITY_Z_RST;
            r_origin    <= bbs_pkg::AXIS_ORIGIN_RST;
            r_cell_size <= bbs_pkg::CELL_SIZE_RST;
            r_prof_cnt  <= bbs_pkg::PROFILE_CNT_RST;
        end else begin
            if (i_cfg_valid) begin
                unique case (bbs_pkg::t_cfg_idx'(i_cfg_index))
                    bbs_pkg::CFG_GRAVITY_X:     r_grav_x    <= i_cfg_data;
                    bbs_pkg::CFG_GRAVITY_Y:     r_grav_y    <= i_cfg_data;
                    bbs_pkg::CFG_GRAVITY_Z:     r_grav_z    <= i_cfg_data;
                    bbs_pkg::CFG_AXIS_ORIGIN:   r_origin    <= i_cfg_data;
                    bbs_pkg::CFG_CELL_SIZE:     r_cell_size <= i_cfg_data[bbs_pkg::SIZE_W-1:0];
                    bbs_pkg::CFG_PROFILE_COUNT: r_prof_cnt  <= i_cfg_data[bbs_pkg::CNT_W-1:0];
                    default: ;
                endcase
            end

            // raise valid when a result is loaded, drop it once taken
            if ((r_state == S_DONE) && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && (i_opcode == bbs_pkg::OP_CELL)) begin
                        r_cidx   <= i_cell_index;
                        r_beta   <= i_expansion_coeff;
                        r_tref   <= i_ref_temperature;
                        r_src[0] <= i_src_in_x;
                        r_src[1] <= i_src_in_y;
                        r_src[2] <= i_src_in_z;
                        r_n      <= n_n;
                        r_state  <= S_X2;
                    end
                end
                S_X2: begin
                    r_x2    <= n_x2;
                    r_state <= S_H0;
                end
                S_H0: begin
                    // at or below the first height, or a single entry
                    r_lo <= mem_q;
                    if ((r_n == CW'(1)) || (r_x2 <= q_h2)) begin
                        r_temp  <= mem_q.temperature;
                        r_state <= S_FAC;
                    end else begin
                        r_state <= S_HN;
                    end
                end
                S_HN: begin
                    r_last <= mem_q;
                    if (r_x2 >= q_h2) begin
                        r_temp  <= mem_q.temperature;
                        r_state <= S_FAC;
                    end else if (r_n == CW'(2)) begin
                        r_hi    <= mem_q;
                        r_state <= S_PREP;
                    end else begin
                        r_k     <= AW'(1);
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // first entry above the height closes the segment
                    if (r_x2 < q_h2) begin
                        r_hi    <= mem_q;
                        r_state <= S_PREP;
                    end else if (k_next == r_n - CW'(1)) begin
                        r_lo    <= mem_q;
                        r_hi    <= r_last;
                        r_state <= S_PREP;
                    end else begin
                        r_lo <= mem_q;
                        r_k  <= AW'(k_next);
                    end
                end
                S_PREP: begin
                    r_rem   <= DENW'(r_x2 - lo_h2);
                    r_den   <= DENW'(hi_h2 - lo_h2);
                    r_bit   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (rem2 >= {1'b0, r_den}) begin
                        r_rem  <= DENW'(rem2 - {1'b0, r_den});
                        r_frac <= {r_frac[DW-2:0], 1'b1};
                    end else begin
                        r_rem  <= DENW'(rem2);
                        r_frac <= {r_frac[DW-2:0], 1'b0};
                    end
                    r_bit <= r_bit + 5'd1;
                    if (r_bit == 5'd31) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_pmag  <= pprod[PW+DW-1:DW];
                    r_pneg  <= dt[PW-1];
                    r_state <= S_TEMP;
                end
                S_TEMP: begin
                    r_temp  <= DW'((PW+1)'(r_lo.temperature) + pval);
                    r_state <= S_FAC;
                end
                S_FAC: begin
                    r_fmag  <= fprod[PW+DW-1:DW];
                    r_fneg  <= diff[PW-1];
                    r_comp  <= COMP_X;
                    r_state <= S_GMUL;
                end
                S_GMUL: begin
                    r_gmag  <= gprod[PW+DW-1:16];
                    r_gneg  <= r_fneg ^ grav[DW-1];
                    r_state <= S_GADD;
                end
                S_GADD: begin
                    r_res[r_comp] <= gsat;
                    unique case (r_comp)
                        COMP_X:  begin r_comp <= COMP_Y; r_state <= S_GMUL; end
                        COMP_Y:  begin r_comp <= COMP_Z; r_state <= S_GMUL; end
                        default: r_state <= S_DONE;
                    endcase
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (!r_out_valid || i_out_ready) begin
                        r_out_x     <= r_res[0];
                        r_out_y     <= r_res[1];
                        r_out_z     <= r_res[2];
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_src_out_x = r_out_x;
    assign o_src_out_y = r_out_y;
    assign o_src_out_z = r_out_z;

endmodule

// ===== hw/rtl/bbs_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the buoyancy source unit, bound to the top level.
// Depends on bbs_pkg and boussinesq_buoyancy_source_unit.
module bbs_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_ready,
    input logic                              i_opcode,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic [bbs_pkg::DATA_W-1:0]        o_src_out_x,
    input logic [bbs_pkg::DATA_W-1:0]        o_src_out_y,
    input logic [bbs_pkg::DATA_W-1:0]        o_src_out_z
);

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a waiting result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_src_out_x)
        && $stable(o_src_out_y) && $stable(o_src_out_z))
        else $error("result dropped or changed while stalled");

    // a profile write never produces a result
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_opcode == bbs_pkg::OP_WRITE) && !o_out_valid
        |=> !o_out_valid)
        else $error("result after a profile write");

    // a cell item keeps the unit busy for at least the next cycle
    a_cell_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_opcode == bbs_pkg::OP_CELL) |=> !o_in_ready)
        else $error("item taken during a cell computation");

endmodule

bind boussinesq_buoyancy_source_unit bbs_checker u_bbs_checker (.*);
